>>> rtl/uct_pkg.sv
// ----------------------------------------------------------------------------
// uct_pkg
// Shared widths, constants and state types of the UCB1 child selector.
// ----------------------------------------------------------------------------
package uct_pkg;

  localparam int CNT_W        = 20;              // visit and win counts
  localparam int IDX_W        = 8;               // child position
  localparam int SCORE_W      = 24;              // unsigned Q8.16
  localparam int WEIGHT_W     = 16;              // unsigned Q4.12
  localparam int FRAC_W       = 16;              // Q.16 fraction bits
  localparam int WEIGHT_FRAC  = 12;
  localparam int DIV_W        = CNT_W + FRAC_W;  // dividend width
  localparam int ROOT_W       = DIV_W / 2;
  localparam int EXP_W        = $clog2(CNT_W);   // log2 integer part
  localparam int LOG_W        = EXP_W + FRAC_W;
  localparam int MANT_W       = 32;              // Q1.31 mantissa
  localparam int MAX_CHILDREN = 256;
  localparam int CHILD_CNT_W  = $clog2(MAX_CHILDREN + 1);

  localparam logic [SCORE_W-1:0]  SCORE_MAX     = '1;
  localparam logic [FRAC_W-1:0]   LN2_Q16       = 16'd45426;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 16'd5793;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPL,
    ST_RATIO,
    ST_ROOT,
    ST_SUM,
    ST_UPDATE,
    ST_EMIT
  } sel_state_t;

  typedef enum logic [1:0] {
    LN_IDLE,
    LN_NORM,
    LN_SQR,
    LN_SCALE
  } ln_state_t;

endpackage

>>> rtl/uct_div.sv
// ----------------------------------------------------------------------------
// uct_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module uct_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [uct_pkg::DIV_W-1:0]  dividend,
  input  logic [uct_pkg::CNT_W-1:0]  divisor,
  output logic [uct_pkg::DIV_W-1:0]  quotient,
  output logic                       done
);

  localparam int IT_W = $clog2(uct_pkg::DIV_W + 1);

  logic [uct_pkg::DIV_W-1:0] q_r;
  logic [uct_pkg::CNT_W-1:0] rem_r;
  logic [uct_pkg::CNT_W-1:0] d_r;
  logic [IT_W-1:0]           cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [uct_pkg::CNT_W:0]   rem_sh;
  logic [uct_pkg::CNT_W:0]   diff;
  logic                      ge;

  assign rem_sh = {rem_r, q_r[uct_pkg::DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, d_r};
  assign diff   = rem_sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= IT_W'(uct_pkg::DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == IT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[uct_pkg::CNT_W-1:0] : rem_sh[uct_pkg::CNT_W-1:0];
      q_r   <= {q_r[uct_pkg::DIV_W-2:0], ge};
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

>>> rtl/uct_ln.sv
// ----------------------------------------------------------------------------
// uct_ln
// Natural log in Q.16: normalize one bit per cycle, then one mantissa
// squaring per fraction bit, then scale by ln 2.
// ----------------------------------------------------------------------------
module uct_ln (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [uct_pkg::CNT_W-1:0] x,
  output logic [uct_pkg::CNT_W-1:0] ln,
  output logic                      done
);

  localparam int SQ_W = $clog2(uct_pkg::FRAC_W + 1);

  uct_pkg::ln_state_t state_r, state_nxt;

  logic [uct_pkg::CNT_W-1:0]   xn_r;
  logic [uct_pkg::EXP_W-1:0]   e_r;
  logic [uct_pkg::MANT_W-1:0]  m_r;
  logic [uct_pkg::FRAC_W-1:0]  frac_r;
  logic [SQ_W-1:0]             cnt_r;
  logic [uct_pkg::CNT_W-1:0]   ln_r;
  logic                        done_r;
  logic [2*uct_pkg::MANT_W-1:0] sq;
  logic [uct_pkg::MANT_W:0]    t;
  logic [uct_pkg::LOG_W+uct_pkg::FRAC_W-1:0] scaled;

  assign sq     = m_r * m_r;
  assign t      = sq[2*uct_pkg::MANT_W-1:uct_pkg::MANT_W-1];
  assign scaled = {e_r, frac_r} * uct_pkg::LN2_Q16;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= uct_pkg::LN_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      uct_pkg::LN_IDLE:  if (start && x > uct_pkg::CNT_W'(1)) state_nxt = uct_pkg::LN_NORM;
      uct_pkg::LN_NORM:  if (xn_r[uct_pkg::CNT_W-1]) state_nxt = uct_pkg::LN_SQR;
      uct_pkg::LN_SQR:   if (cnt_r == SQ_W'(1)) state_nxt = uct_pkg::LN_SCALE;
      uct_pkg::LN_SCALE: state_nxt = uct_pkg::LN_IDLE;
      default:           state_nxt = uct_pkg::LN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (start) begin
      done_r <= !(x > uct_pkg::CNT_W'(1));
    end else if (state_r == uct_pkg::LN_SCALE) begin
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      uct_pkg::LN_IDLE: begin
        if (start) begin
          xn_r   <= x;
          e_r    <= uct_pkg::EXP_W'(uct_pkg::CNT_W - 1);
          frac_r <= '0;
          ln_r   <= '0;
        end
      end
      uct_pkg::LN_NORM: begin
        if (xn_r[uct_pkg::CNT_W-1]) begin
          m_r   <= {xn_r, {(uct_pkg::MANT_W-uct_pkg::CNT_W){1'b0}}};
          cnt_r <= SQ_W'(uct_pkg::FRAC_W);
        end else begin
          xn_r <= {xn_r[uct_pkg::CNT_W-2:0], 1'b0};
          e_r  <= e_r - 1'b1;
        end
      end
      uct_pkg::LN_SQR: begin
        // square in Q1.31, renormalize when it reaches two
        frac_r <= {frac_r[uct_pkg::FRAC_W-2:0], t[uct_pkg::MANT_W]};
        m_r    <= t[uct_pkg::MANT_W] ? t[uct_pkg::MANT_W:1] : t[uct_pkg::MANT_W-1:0];
        cnt_r  <= cnt_r - 1'b1;
      end
      uct_pkg::LN_SCALE: begin
        ln_r <= scaled[uct_pkg::CNT_W+uct_pkg::FRAC_W-1:uct_pkg::FRAC_W];
      end
      default: ;
    endcase
  end

  assign ln   = ln_r;
  assign done = done_r;

endmodule

>>> rtl/uct_sqrt.sv
// ----------------------------------------------------------------------------
// uct_sqrt
// Integer square root, one radicand digit of two bits per cycle.
// ----------------------------------------------------------------------------
module uct_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [uct_pkg::DIV_W-1:0]   radicand,
  output logic [uct_pkg::ROOT_W-1:0]  root,
  output logic                        done
);

  localparam int IT_W  = $clog2(uct_pkg::ROOT_W + 1);
  localparam int REM_W = uct_pkg::ROOT_W + 2;

  logic [uct_pkg::DIV_W-1:0]  rad_r;
  logic [REM_W-1:0]           rem_r;
  logic [uct_pkg::ROOT_W-1:0] root_r;
  logic [IT_W-1:0]            cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [REM_W+1:0]           rem_sh;
  logic [REM_W+1:0]           trial;
  logic                       ge;

  assign rem_sh = {rem_r, rad_r[uct_pkg::DIV_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= IT_W'(uct_pkg::ROOT_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == IT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[uct_pkg::DIV_W-3:0], 2'b00};
      rem_r  <= ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
      root_r <= {root_r[uct_pkg::ROOT_W-2:0], ge};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

>>> rtl/uct_child_select_top.sv
// ----------------------------------------------------------------------------
// uct_child_select_top
// UCB1 child selection: scores a stream of children and reports the first
// child with the highest score when the last child of a node arrives.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | parent_visits, child_wins,
//          |           |                     | child_visits, last_child
//  out     | output    | out_valid/out_ready | best_index, best_score
//  cfg     | input     | cfg_wr_en           | cfg_wr_data (explore_weight)
//
//  a new child is accepted only in idle. after acceptance, the win ratio
//  divide runs beside the log unit; then the ln/visits divide reuses the
//  divider and the root runs on the square root unit, both bit-serial;
//  the weighted product is taken when the root is done, then sum and update.
//  an unvisited child or one past the child limit goes straight to update.
//  a last child then goes through emit; reset is synchronous, no clearing pass.
//  a result still waiting on out_ready holds the next node's last child in
//  emit, and the input stalls until the result is taken.
// ----------------------------------------------------------------------------
module uct_child_select_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [uct_pkg::CNT_W-1:0]     in_parent_visits,
  input  logic [uct_pkg::CNT_W-1:0]     in_child_wins,
  input  logic [uct_pkg::CNT_W-1:0]     in_child_visits,
  input  logic                          in_last_child,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [uct_pkg::IDX_W-1:0]     out_best_index,
  output logic [uct_pkg::SCORE_W-1:0]   out_best_score,
  input  logic                          cfg_wr_en,
  input  logic [uct_pkg::WEIGHT_W-1:0]  cfg_wr_data
);

  localparam int EXPL_W = uct_pkg::ROOT_W + uct_pkg::WEIGHT_W - uct_pkg::WEIGHT_FRAC;

  uct_pkg::sel_state_t state_r, state_nxt;

  logic [uct_pkg::WEIGHT_W-1:0]    weight_r;
  logic [uct_pkg::CNT_W-1:0]       visits_r;
  logic                            last_r;
  logic                            quick_r;
  logic [uct_pkg::DIV_W-1:0]       exploit_r;
  logic [EXPL_W-1:0]               explore_r;
  logic [uct_pkg::SCORE_W-1:0]     score_r;
  logic [uct_pkg::SCORE_W-1:0]     top_score_r;
  logic [uct_pkg::IDX_W-1:0]       top_index_r;
  logic [uct_pkg::CHILD_CNT_W-1:0] child_cnt_r;
  logic                            out_valid_r;
  logic [uct_pkg::IDX_W-1:0]       out_index_r;
  logic [uct_pkg::SCORE_W-1:0]     out_score_r;

  logic                            accept;
  logic                            room;
  logic                            div_start, ln_start, sqrt_start;
  logic [uct_pkg::DIV_W-1:0]       div_dividend;
  logic [uct_pkg::CNT_W-1:0]       div_divisor;
  logic [uct_pkg::DIV_W-1:0]       quotient;
  logic                            div_done, ln_done, sqrt_done;
  logic [uct_pkg::CNT_W-1:0]       ln_val;
  logic [uct_pkg::ROOT_W-1:0]      root;
  logic [uct_pkg::ROOT_W+uct_pkg::WEIGHT_W-1:0] wprod;
  logic [uct_pkg::DIV_W:0]         sum;

  assign in_ready = (state_r == uct_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign room     = child_cnt_r < uct_pkg::CHILD_CNT_W'(uct_pkg::MAX_CHILDREN);
  assign wprod    = weight_r * root;
  assign sum      = {1'b0, exploit_r} + (uct_pkg::DIV_W + 1)'(explore_r);

  uct_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .quotient(quotient), .done(div_done)
  );

  uct_ln u_ln (
    .clk(clk), .rst_n(rst_n), .start(ln_start), .x(in_parent_visits),
    .ln(ln_val), .done(ln_done)
  );

  uct_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start),
    .radicand({quotient[uct_pkg::CNT_W-1:0], {uct_pkg::FRAC_W{1'b0}}}),
    .root(root), .done(sqrt_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= uct_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    div_start    = 1'b0;
    ln_start     = 1'b0;
    sqrt_start   = 1'b0;
    div_dividend = {in_child_wins, {uct_pkg::FRAC_W{1'b0}}};
    div_divisor  = in_child_visits;
    unique case (state_r)
      uct_pkg::ST_IDLE: begin
        if (accept) begin
          if (!room || in_child_visits == '0) begin
            state_nxt = uct_pkg::ST_UPDATE;
          end else begin
            div_start = 1'b1;
            ln_start  = 1'b1;
            state_nxt = uct_pkg::ST_EXPL;
          end
        end
      end
      uct_pkg::ST_EXPL: begin
        div_dividend = {{uct_pkg::FRAC_W{1'b0}}, ln_val};
        div_divisor  = visits_r;
        if (div_done && ln_done) begin
          div_start = 1'b1;
          state_nxt = uct_pkg::ST_RATIO;
        end
      end
      uct_pkg::ST_RATIO: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_nxt  = uct_pkg::ST_ROOT;
        end
      end
      uct_pkg::ST_ROOT:   if (sqrt_done) state_nxt = uct_pkg::ST_SUM;
      uct_pkg::ST_SUM:    state_nxt = uct_pkg::ST_UPDATE;
      uct_pkg::ST_UPDATE: state_nxt = last_r ? uct_pkg::ST_EMIT : uct_pkg::ST_IDLE;
      uct_pkg::ST_EMIT:   if (!out_valid_r || out_ready) state_nxt = uct_pkg::ST_IDLE;
      default:            state_nxt = uct_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) weight_r <= uct_pkg::WEIGHT_RESET;
    else if (cfg_wr_en) weight_r <= cfg_wr_data;
  end

  // datapath for one child
  always_ff @(posedge clk) begin
    if (accept) begin
      visits_r <= in_child_visits;
      last_r   <= in_last_child;
      quick_r  <= !room;
      score_r  <= uct_pkg::SCORE_MAX;
    end
    if (state_r == uct_pkg::ST_EXPL && div_done && ln_done) exploit_r <= quotient;
    if (state_r == uct_pkg::ST_ROOT && sqrt_done)
      explore_r <= wprod[uct_pkg::ROOT_W+uct_pkg::WEIGHT_W-1:uct_pkg::WEIGHT_FRAC];
    if (state_r == uct_pkg::ST_SUM)
      score_r <= (|sum[uct_pkg::DIV_W:uct_pkg::SCORE_W]) ? uct_pkg::SCORE_MAX
                                                          : sum[uct_pkg::SCORE_W-1:0];
  end

  // running best and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_score_r <= '0;
      top_index_r <= '0;
      child_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == uct_pkg::ST_UPDATE && !quick_r) begin
        if (child_cnt_r == '0 || score_r > top_score_r) begin
          top_score_r <= score_r;
          top_index_r <= child_cnt_r[uct_pkg::IDX_W-1:0];
        end
        child_cnt_r <= child_cnt_r + 1'b1;
      end
      if (state_r == uct_pkg::ST_EMIT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        out_index_r <= top_index_r;
        out_score_r <= top_score_r;
        top_score_r <= '0;
        top_index_r <= '0;
        child_cnt_r <= '0;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_index = out_index_r;
  assign out_best_score = out_score_r;

`ifndef SYNTH
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    child_cnt_r <= uct_pkg::CHILD_CNT_W'(uct_pkg::MAX_CHILDREN))
    else $error("child count past limit");

  a_unvisited_fast: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_child_visits == '0 |=> state_r == uct_pkg::ST_UPDATE)
    else $error("unvisited child not taken on the short path");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == uct_pkg::ST_EMIT))
    else $error("result raised outside emit");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == uct_pkg::ST_EMIT && state_nxt == uct_pkg::ST_IDLE |=> child_cnt_r == '0)
    else $error("node state not cleared after result");
`endif

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UCB1 child selector. A directed table and
// random nodes are sent over the input channel under several idle and
// stall mixes. Each transaction is scored by a bit-exact model in the
// bench, and every result is checked against the oldest pending best.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT      = 1000000;
  localparam int DRAIN_WAIT = 300;
  localparam int HOLD_LEN   = 3000;

  typedef struct {
    logic [uct_pkg::CNT_W-1:0]   parent;
    logic [uct_pkg::CNT_W-1:0]   wins;
    logic [uct_pkg::CNT_W-1:0]   visits;
    bit                          last;
    bit                          known;
    logic [uct_pkg::IDX_W-1:0]   idx;
    logic [uct_pkg::SCORE_W-1:0] score;
  } child_row_t;

  typedef struct {
    logic [uct_pkg::IDX_W-1:0]   idx;
    logic [uct_pkg::SCORE_W-1:0] score;
  } best_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [uct_pkg::CNT_W-1:0] in_parent_visits = '0;
  logic [uct_pkg::CNT_W-1:0] in_child_wins = '0;
  logic [uct_pkg::CNT_W-1:0] in_child_visits = '0;
  logic in_last_child = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [uct_pkg::IDX_W-1:0] out_best_index;
  logic [uct_pkg::SCORE_W-1:0] out_best_score;
  logic cfg_wr_en = 1'b0;
  logic [uct_pkg::WEIGHT_W-1:0] cfg_wr_data = '0;

  uct_child_select_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_parent_visits (in_parent_visits),
    .in_child_wins    (in_child_wins),
    .in_child_visits  (in_child_visits),
    .in_last_child    (in_last_child),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_best_index   (out_best_index),
    .out_best_score   (out_best_score),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // bench copy of the selector state
  logic [uct_pkg::WEIGHT_W-1:0] mdl_weight = uct_pkg::WEIGHT_RESET;
  logic [uct_pkg::SCORE_W-1:0]  mdl_top_score = '0;
  logic [uct_pkg::IDX_W-1:0]    mdl_top_index = '0;
  int unsigned                  mdl_seen = 0;

  best_t pending_best[$];
  child_row_t dir_tab[$];
  int errors = 0;
  int cycles = 0;
  int snd_idle = 0;
  int rcv_stall = 0;
  int hold_go = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic longint unsigned ln_fix(longint unsigned x);
    int e;
    longint unsigned m, frac;
    if (x <= 1) return 0;
    e = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    m = x << (31 - e);
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (((longint'(e) << 16) | frac) * 45426) >> 16;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [uct_pkg::SCORE_W-1:0] ucb_score(logic [uct_pkg::CNT_W-1:0] p,
                                                            logic [uct_pkg::CNT_W-1:0] w,
                                                            logic [uct_pkg::CNT_W-1:0] v);
    longint unsigned exploit, ratio, root, explore, sum;
    if (v == 0) return uct_pkg::SCORE_MAX;
    exploit = (longint'(w) << 16) / v;
    if (exploit > uct_pkg::SCORE_MAX) return uct_pkg::SCORE_MAX;
    ratio = ln_fix(64'(p)) / v;
    root = isqrt(ratio << 16);
    explore = (longint'(mdl_weight) * root) >> 12;
    sum = exploit + explore;
    return (sum > uct_pkg::SCORE_MAX) ? uct_pkg::SCORE_MAX : sum[uct_pkg::SCORE_W-1:0];
  endfunction

  // advance the model by one accepted child; queue the best on the last one
  task automatic score_child(child_row_t c);
    logic [uct_pkg::SCORE_W-1:0] s;
    best_t b;
    if (mdl_seen < uct_pkg::MAX_CHILDREN) begin
      s = ucb_score(c.parent, c.wins, c.visits);
      if (mdl_seen == 0 || s > mdl_top_score) begin
        mdl_top_score = s;
        mdl_top_index = mdl_seen[uct_pkg::IDX_W-1:0];
      end
      mdl_seen++;
    end
    if (c.last) begin
      b.idx = c.known ? c.idx : mdl_top_index;
      b.score = c.known ? c.score : mdl_top_score;
      pending_best.push_back(b);
      mdl_top_score = '0;
      mdl_top_index = '0;
      mdl_seen = 0;
    end
  endtask

  // called at a clock edge; returns at the edge of acceptance or after a random idle gap
  task automatic send_child(child_row_t c);
    in_valid <= 1'b1;
    in_parent_visits <= c.parent;
    in_child_wins <= c.wins;
    in_child_visits <= c.visits;
    in_last_child <= c.last;
    do @(posedge clk); while (!in_ready);
    score_child(c);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
  endtask

  function automatic child_row_t rand_child(logic [uct_pkg::CNT_W-1:0] p, bit last);
    child_row_t c;
    int sel;
    c.parent = p;
    c.last = last;
    c.known = 1'b0;
    c.idx = '0;
    c.score = '0;
    sel = $urandom_range(99);
    if (sel < 10) c.visits = '0;
    else c.visits = uct_pkg::CNT_W'($urandom_range(1,
                      (1 << $urandom_range(1, uct_pkg::CNT_W)) - 1));
    if (sel >= 90 || c.visits == 0) c.wins = uct_pkg::CNT_W'($urandom);
    else c.wins = uct_pkg::CNT_W'($urandom_range(0, c.visits));
    return c;
  endfunction

  task automatic send_node(int n);
    logic [uct_pkg::CNT_W-1:0] p;
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) p = '0;
    else if (sel < 10) p = uct_pkg::CNT_W'(1);
    else if (sel < 15) p = '1;
    else p = uct_pkg::CNT_W'($urandom);
    for (int i = 0; i < n; i++) send_child(rand_child(p, i == n - 1));
  endtask

  // sender pauses until every result is in, lets the block drain, then writes the weight
  task automatic drain_and_set(logic [uct_pkg::WEIGHT_W-1:0] w);
    in_valid <= 1'b0;
    while (pending_best.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mdl_weight = w;
  endtask

  // receiver: random stall plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_go) begin
      hold_seen = hold_go;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  always @(posedge clk) begin
    best_t b;
    if (out_valid && out_ready) begin
      if (pending_best.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: index %0d score %0h", out_best_index,
                   out_best_score);
      end else begin
        b = pending_best.pop_front();
        if (out_best_index !== b.idx || out_best_score !== b.score) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected index %0d score %0h, got index %0d score %0h",
                     b.idx, b.score, out_best_index, out_best_score);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic child_row_t row(int p, int w, int v, bit l, bit k = 0,
                                     int i = 0, int s = 0);
    child_row_t c;
    c.parent = uct_pkg::CNT_W'(p);
    c.wins = uct_pkg::CNT_W'(w);
    c.visits = uct_pkg::CNT_W'(v);
    c.last = l;
    c.known = k;
    c.idx = uct_pkg::IDX_W'(i);
    c.score = uct_pkg::SCORE_W'(s);
    return c;
  endfunction

  initial begin
    logic [uct_pkg::WEIGHT_W-1:0] weights[4];
    int idle_mix[4][2];
    int smax;
    smax = int'(uct_pkg::SCORE_MAX);
    weights = '{16'h0000, 16'hFFFF, 16'h1000, 16'h0000};
    weights[3] = uct_pkg::WEIGHT_W'($urandom);
    idle_mix = '{'{0, 0}, '{84, 0}, '{0, 84}, '{27, 27}};

    dir_tab.push_back(row(1, 5, 5, 1, 1, 0, 65536));          // parent of one
    dir_tab.push_back(row(0, 1, 2, 1, 1, 0, 32768));          // parent of zero
    dir_tab.push_back(row(1000, 0, 0, 1, 1, 0, smax));        // unvisited
    dir_tab.push_back(row('hFFFFF, 'hFFFFF, 1, 1, 1, 0, smax)); // wins above visits
    dir_tab.push_back(row(1, 0, 5, 1, 1, 0, 0));              // first child wins at zero
    dir_tab.push_back(row('hFFFFF, 0, 'hFFFFF, 1));
    dir_tab.push_back(row('hFFFFF, 'hFFFFF, 'hFFFFF, 1));
    dir_tab.push_back(row(2, 0, 1, 1));
    dir_tab.push_back(row(100, 3, 4, 0));                     // ties: first max kept
    dir_tab.push_back(row(100, 3, 4, 0));
    dir_tab.push_back(row(100, 3, 4, 1));
    dir_tab.push_back(row(50, 1, 10, 0));
    dir_tab.push_back(row(50, 9, 10, 0));
    dir_tab.push_back(row(50, 5, 10, 1));
    dir_tab.push_back(row(7, 0, 0, 0));
    dir_tab.push_back(row(7, 0, 0, 1, 1, 0, smax));
    dir_tab.push_back(row(9, 1, 2, 0));
    dir_tab.push_back(row(9, 0, 0, 1, 1, 1, smax));
    dir_tab.push_back(row('h80000, 'h12345, 'h54321, 1));
    dir_tab.push_back(row(3, 1, 1, 1));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_child(dir_tab[i]);

    for (int ph = 0; ph < 4; ph++) begin
      drain_and_set(weights[ph]);
      snd_idle = idle_mix[ph][0];
      rcv_stall = idle_mix[ph][1];
      if (ph == 0) begin
        // past the child limit: the tail is not scored
        for (int i = 0; i < 270; i++)
          send_child(row(1000, i, (i % 3 == 0) ? 0 : i, i == 269));
      end
      if (ph == 2) hold_go++;
      for (int n = 0; n < 6; n++) send_node($urandom_range(1, 7));
    end

    drain_and_set(uct_pkg::WEIGHT_RESET);
    snd_idle = 0;
    rcv_stall = 0;
    for (int n = 0; n < 10; n++) send_node($urandom_range(1, 3));
    in_valid <= 1'b0;
    while (pending_best.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/uct_pkg.sv
rtl/uct_div.sv
rtl/uct_ln.sv
rtl/uct_sqrt.sv
rtl/uct_child_select_top.sv
tb/tb_top.sv
